>>> hw/rtl/shadow_volume_silhouette_builder_macros.svh
// ----------------------------------------------------------------------------
// Shadow volume silhouette builder assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SHADOW_VOLUME_SILHOUETTE_BUILDER_MACROS_SVH
`define SHADOW_VOLUME_SILHOUETTE_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SVSB_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("svsb assertion failed");
// Next-cycle implication.
`define SVSB_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("svsb assertion failed");
`else
`define SVSB_ASSERT_IMP(label, clk, rstn, pre, post)
`define SVSB_ASSERT_NXT(label, clk, rstn, pre, post)
`endif

`endif

>>> hw/rtl/svsb_pkg.sv
// ----------------------------------------------------------------------------
// svsb_pkg
// Shared types and codes of the shadow volume silhouette builder.
// ----------------------------------------------------------------------------
`default_nettype none

package svsb_pkg;

    localparam int VIDX_W  = 10;
    localparam int COORD_W = 16;

    // Request codes.
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TRI   = 2'd1;
    localparam logic [1:0] REQ_EMIT  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Emission phases.
    localparam logic [1:0] PH_FACES = 2'd0;
    localparam logic [1:0] PH_BACK  = 2'd1;
    localparam logic [1:0] PH_EDGES = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LIGHT_X = 2'd0;
    localparam logic [1:0] CFG_LIGHT_Y = 2'd1;
    localparam logic [1:0] CFG_LIGHT_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vertex_t;

    typedef struct packed {
        logic [VIDX_W-1:0] a;
        logic [VIDX_W-1:0] b;
    } edge_t;

    typedef struct packed {
        logic [VIDX_W-1:0] a;
        logic [VIDX_W-1:0] b;
        logic [VIDX_W-1:0] c;
    } face_t;

    typedef struct packed {
        logic  toggle;
        logic  clear;
        edge_t e;
    } edge_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/svsb_edge_cell.sv
// ----------------------------------------------------------------------------
// svsb_edge_cell
// One slot of the ordered edge set: matches the broadcast edge, shifts up
// from its neighbor on removal and takes the edge on append.
// ----------------------------------------------------------------------------
`default_nettype none

module svsb_edge_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 10
) (
    input  wire logic                aclk,
    input  wire svsb_pkg::edge_cmd_t cmd,
    input  wire logic [CNT_W-1:0]    count,
    input  wire logic                found,
    input  wire logic                match_in,
    input  wire svsb_pkg::edge_t     next_link,
    output logic                     match_out,
    output logic                     hit,
    output svsb_pkg::edge_t          link_q
);
    import svsb_pkg::*;

    edge_t link_reg;
    logic  in_use;

    // Undirected compare against the broadcast edge, only for occupied slots.
    always_comb begin
        in_use    = CNT_W'(IDX) < count;
        hit       = in_use &&
                    ((cmd.e.a == link_reg.a && cmd.e.b == link_reg.b) ||
                     (cmd.e.a == link_reg.b && cmd.e.b == link_reg.a));
        match_out = match_in | hit;
        link_q    = link_reg;
    end

    // Removal shifts every slot at or after the match up by one.
    always_ff @(posedge aclk) begin
        if (cmd.toggle) begin
            if (found) begin
                if (match_out) begin
                    link_reg <= next_link;
                end
            end else if (count == CNT_W'(IDX)) begin
                link_reg <= cmd.e;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/svsb_edge_chain.sv
// ----------------------------------------------------------------------------
// svsb_edge_chain
// Ordered edge set built as a row of cells with a fill count and one
// registered read port for emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shadow_volume_silhouette_builder_macros.svh"

module svsb_edge_chain #(
    parameter int MAX_EDGES = 512,
    parameter int EC_W      = $clog2(MAX_EDGES + 1),
    parameter int EA_W      = $clog2(MAX_EDGES)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire svsb_pkg::edge_cmd_t cmd,
    input  wire logic                rd_en,
    input  wire logic [EA_W-1:0]     rd_idx,
    output svsb_pkg::edge_t          rd_data,
    output logic [EC_W-1:0]          count,
    output logic                     ovf
);
    import svsb_pkg::*;

    logic [MAX_EDGES:0]   match;
    logic [MAX_EDGES-1:0] hits;
    edge_t                links [MAX_EDGES];
    logic [EC_W-1:0]      count_reg;
    edge_t                rd_reg;
    logic                 found;

    assign match[0] = 1'b0;
    assign found    = match[MAX_EDGES];
    assign count    = count_reg;
    assign rd_data  = rd_reg;
    assign ovf      = cmd.toggle && !found && (count_reg == EC_W'(MAX_EDGES));

    // Row of cells; each but the last takes its successor's entry on removal.
    for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
        edge_t nxt;
        if (i == MAX_EDGES - 1) begin : g_last
            assign nxt = links[i];
        end else begin : g_mid
            assign nxt = links[i+1];
        end
        svsb_edge_cell #(
            .IDX   (i),
            .CNT_W (EC_W)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .count     (count_reg),
            .found     (found),
            .match_in  (match[i]),
            .next_link (nxt),
            .match_out (match[i+1]),
            .hit       (hits[i]),
            .link_q    (links[i])
        );
    end

    // Fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.toggle) begin
            if (found) begin
                count_reg <= count_reg - EC_W'(1);
            end else if (count_reg != EC_W'(MAX_EDGES)) begin
                count_reg <= count_reg + EC_W'(1);
            end
        end
    end

    // Emission read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= links[rd_idx];
        end
    end

    `SVSB_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= EC_W'(MAX_EDGES))
    `SVSB_ASSERT_IMP(a_single_match, aclk, aresetn, cmd.toggle, $onehot0(hits))
    `SVSB_ASSERT_NXT(a_clear_empty, aclk, aresetn, cmd.clear, count_reg == '0)

endmodule

`default_nettype wire

>>> hw/rtl/svsb_facing.sv
// ----------------------------------------------------------------------------
// svsb_facing
// Five-stage facing test: normal by cross product, then (light - a) . n > 0.
// ----------------------------------------------------------------------------
`default_nettype none

module svsb_facing (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire svsb_pkg::vertex_t va,
    input  wire svsb_pkg::vertex_t vb,
    input  wire svsb_pkg::vertex_t vc,
    input  wire svsb_pkg::vertex_t light,
    output logic                   out_valid,
    output logic                   lit
);
    import svsb_pkg::*;

    logic [4:0] vld_reg;

    logic signed [16:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [16:0] lx_reg, ly_reg, lz_reg;
    logic signed [33:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [16:0] lx2_reg, ly2_reg, lz2_reg;
    logic signed [34:0] nx_reg, ny_reg, nz_reg;
    logic signed [16:0] lx3_reg, ly3_reg, lz3_reg;
    logic signed [51:0] qx_reg, qy_reg, qz_reg;
    logic signed [53:0] dot;
    logic               lit_reg;

    assign out_valid = vld_reg[4];
    assign lit       = lit_reg;
    assign dot       = 54'(qx_reg) + 54'(qy_reg) + 54'(qz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Stage data path, one multiplier per product between registers.
    always_ff @(posedge aclk) begin
        ux_reg  <= 17'(vb.x) - 17'(va.x);
        uy_reg  <= 17'(vb.y) - 17'(va.y);
        uz_reg  <= 17'(vb.z) - 17'(va.z);
        vx_reg  <= 17'(vc.x) - 17'(va.x);
        vy_reg  <= 17'(vc.y) - 17'(va.y);
        vz_reg  <= 17'(vc.z) - 17'(va.z);
        lx_reg  <= 17'(light.x) - 17'(va.x);
        ly_reg  <= 17'(light.y) - 17'(va.y);
        lz_reg  <= 17'(light.z) - 17'(va.z);

        p0_reg  <= uy_reg * vz_reg;
        p1_reg  <= uz_reg * vy_reg;
        p2_reg  <= uz_reg * vx_reg;
        p3_reg  <= ux_reg * vz_reg;
        p4_reg  <= ux_reg * vy_reg;
        p5_reg  <= uy_reg * vx_reg;
        lx2_reg <= lx_reg;
        ly2_reg <= ly_reg;
        lz2_reg <= lz_reg;

        nx_reg  <= 35'(p0_reg) - 35'(p1_reg);
        ny_reg  <= 35'(p2_reg) - 35'(p3_reg);
        nz_reg  <= 35'(p4_reg) - 35'(p5_reg);
        lx3_reg <= lx2_reg;
        ly3_reg <= ly2_reg;
        lz3_reg <= lz2_reg;

        qx_reg  <= lx3_reg * nx_reg;
        qy_reg  <= ly3_reg * ny_reg;
        qz_reg  <= lz3_reg * nz_reg;

        lit_reg <= dot > 54'sd0;
    end

endmodule

`default_nettype wire

>>> hw/rtl/shadow_volume_silhouette_builder.sv
// ----------------------------------------------------------------------------
// shadow_volume_silhouette_builder
// Builds a shadow volume from a loaded mesh: facing test, lit face list,
// silhouette edge set and triangle streaming.
// ----------------------------------------------------------------------------
// One request is worked at a time. A vertex load, a clear and an ignored
// triangle are done without leaving the idle state. A triangle reads its
// three corners in turn through the single read port of the vertex store,
// presents them to the facing pipeline and waits for its result, the face
// write falling with that result, and when lit and the face list is not
// full toggles each of its edges in turn in the edge cell row. An emit
// fetches the face or edge and then reads the vertex store for each output
// word, each word waiting until the output register is free; an emit with
// nothing left gives only the word that says so. A finished word waits in the
// output register while the next request is taken. No memory needs a
// clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shadow_volume_silhouette_builder_macros.svh"

module shadow_volume_silhouette_builder #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_FACES    = 1024,
    parameter int MAX_EDGES    = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [9:0]  s_vertex_index,
    input  wire logic [15:0] s_coord_x,
    input  wire logic [15:0] s_coord_y,
    input  wire logic [15:0] s_coord_z,
    input  wire logic [9:0]  s_corner_a,
    input  wire logic [9:0]  s_corner_b,
    input  wire logic [9:0]  s_corner_c,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_pos_x,
    output logic [15:0]      m_pos_y,
    output logic [15:0]      m_pos_z,
    output logic             m_pos_w,
    output logic             m_last_of_triangle,
    output logic             m_nothing_left,
    output logic             m_overflow
);
    import svsb_pkg::*;

    localparam int VA_W  = $clog2(MAX_VERTICES);
    localparam int FA_W  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int FC_W  = $clog2(MAX_FACES + 1);
    localparam int EC_W  = $clog2(MAX_EDGES + 1);
    localparam int EA_W  = $clog2(MAX_EDGES);
    localparam int PTR_W = (FC_W > EC_W) ? FC_W : EC_W;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_TRI_B    = 4'd1;
    localparam logic [3:0] ST_TRI_C    = 4'd2;
    localparam logic [3:0] ST_TRI_F    = 4'd3;
    localparam logic [3:0] ST_TRI_WAIT = 4'd4;
    localparam logic [3:0] ST_EDGE0    = 4'd5;
    localparam logic [3:0] ST_EDGE1    = 4'd6;
    localparam logic [3:0] ST_EDGE2    = 4'd7;
    localparam logic [3:0] ST_EM_FETCH = 4'd8;
    localparam logic [3:0] ST_EM_RD    = 4'd9;
    localparam logic [3:0] ST_EM_OUT   = 4'd10;
    localparam logic [3:0] ST_EM_NONE  = 4'd11;

    logic [3:0]        state_reg;
    vertex_t           light_reg;
    face_t             tri_reg;
    vertex_t           va_reg, vb_reg, vrd_reg;
    vertex_t           vmem [MAX_VERTICES];
    face_t             fmem [MAX_FACES];
    face_t             frd_reg;
    logic [FC_W-1:0]   fc_reg;
    logic [1:0]        phase_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic              half_reg;
    logic              ovf_reg;
    logic [VIDX_W-1:0] vi_reg [3];
    logic [2:0]        vw_reg;
    logic [1:0]        k_reg;

    logic              m_valid_reg;
    vertex_t           m_pos_reg;
    logic              m_w_reg, m_last_reg, m_none_reg, m_ovf_reg;

    logic              accept, out_free, tri_ok, load_ok, word_load;
    logic              vrd_en, vwe, face_we;
    logic [VA_W-1:0]   vaddr, waddr;
    logic [1:0]        r_ph;
    logic [PTR_W-1:0]  r_ptr;
    logic              r_half;
    edge_cmd_t         ecmd;
    logic              erd_en;
    edge_t             erd_data;
    logic [EC_W-1:0]   ecount;
    logic              eovf;
    logic              f_valid, f_lit;
    vertex_t           load_v;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign word_load = ((state_reg == ST_EM_OUT) || (state_reg == ST_EM_NONE)) && out_free;
    assign tri_ok   = (32'(s_corner_a) < MAX_VERTICES) && (32'(s_corner_b) < MAX_VERTICES)
                      && (32'(s_corner_c) < MAX_VERTICES);
    assign load_ok  = 32'(s_vertex_index) < MAX_VERTICES;
    assign load_v   = '{x: s_coord_x, y: s_coord_y, z: s_coord_z};
    assign face_we  = (state_reg == ST_TRI_WAIT) && f_valid && f_lit
                      && (fc_reg != FC_W'(MAX_FACES));

    // Skip empty emission phases to find where the next emit reads.
    always_comb begin
        r_ph   = phase_reg;
        r_ptr  = ptr_reg;
        r_half = half_reg;
        if (r_ph == PH_FACES && r_ptr >= PTR_W'(fc_reg)) begin
            r_ph  = PH_BACK;
            r_ptr = '0;
        end
        if (r_ph == PH_BACK && r_ptr >= PTR_W'(fc_reg)) begin
            r_ph   = PH_EDGES;
            r_ptr  = '0;
            r_half = 1'b0;
        end
        if (r_ph == PH_EDGES && r_ptr >= PTR_W'(ecount)) begin
            r_ph   = PH_DONE;
            r_ptr  = '0;
            r_half = 1'b0;
        end
    end

    // Vertex store port control.
    always_comb begin
        vrd_en = 1'b0;
        vaddr  = VA_W'(tri_reg.b);
        vwe    = accept && s_req_type == REQ_LOAD && load_ok;
        waddr  = VA_W'(s_vertex_index);
        unique case (state_reg)
            ST_IDLE: begin
                vrd_en = accept && s_req_type == REQ_TRI && tri_ok;
                vaddr  = VA_W'(s_corner_a);
            end
            ST_TRI_B: begin
                vrd_en = 1'b1;
                vaddr  = VA_W'(tri_reg.b);
            end
            ST_TRI_C: begin
                vrd_en = 1'b1;
                vaddr  = VA_W'(tri_reg.c);
            end
            ST_EM_RD: begin
                vrd_en = 1'b1;
                vaddr  = VA_W'(vi_reg[k_reg]);
            end
            default: begin
                vrd_en = 1'b0;
            end
        endcase
    end

    // Edge set commands: the three toggles of a lit face, and clear.
    always_comb begin
        ecmd.toggle = 1'b0;
        ecmd.clear  = accept && s_req_type == REQ_CLEAR;
        ecmd.e      = '{a: tri_reg.a, b: tri_reg.b};
        erd_en      = accept && s_req_type == REQ_EMIT;
        unique case (state_reg)
            ST_EDGE0: begin
                ecmd.toggle = 1'b1;
                ecmd.e      = '{a: tri_reg.a, b: tri_reg.b};
            end
            ST_EDGE1: begin
                ecmd.toggle = 1'b1;
                ecmd.e      = '{a: tri_reg.b, b: tri_reg.c};
            end
            ST_EDGE2: begin
                ecmd.toggle = 1'b1;
                ecmd.e      = '{a: tri_reg.c, b: tri_reg.a};
            end
            default: begin
                ecmd.toggle = 1'b0;
            end
        endcase
    end

    // Vertex store.
    always_ff @(posedge aclk) begin
        if (vwe) begin
            vmem[waddr] <= load_v;
        end
        if (vrd_en) begin
            vrd_reg <= vmem[vaddr];
        end
    end

    // Lit face list.
    always_ff @(posedge aclk) begin
        if (face_we) begin
            fmem[FA_W'(fc_reg)] <= tri_reg;
        end
        if (erd_en) begin
            frd_reg <= fmem[FA_W'(r_ptr)];
        end
    end

    svsb_edge_chain #(
        .MAX_EDGES (MAX_EDGES),
        .EC_W      (EC_W),
        .EA_W      (EA_W)
    ) u_edges (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ecmd),
        .rd_en   (erd_en),
        .rd_idx  (EA_W'(r_ptr)),
        .rd_data (erd_data),
        .count   (ecount),
        .ovf     (eovf)
    );

    svsb_facing u_facing (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (state_reg == ST_TRI_F),
        .va        (va_reg),
        .vb        (vb_reg),
        .vc        (vrd_reg),
        .light     (light_reg),
        .out_valid (f_valid),
        .lit       (f_lit)
    );

    // Light position registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LIGHT_X: light_reg.x <= cfg_data;
                CFG_LIGHT_Y: light_reg.y <= cfg_data;
                CFG_LIGHT_Z: light_reg.z <= cfg_data;
                default:     light_reg   <= light_reg;
            endcase
        end
    end

    // Request sequencer, emission state and output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fc_reg      <= '0;
            phase_reg   <= PH_FACES;
            ptr_reg     <= '0;
            half_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // A new word replaces a taken one in the same cycle.
            if (word_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (eovf) begin
                ovf_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (s_req_type)
                            REQ_TRI: begin
                                if (tri_ok) begin
                                    tri_reg   <= '{a: s_corner_a, b: s_corner_b,
                                                   c: s_corner_c};
                                    phase_reg <= PH_FACES;
                                    ptr_reg   <= '0;
                                    half_reg  <= 1'b0;
                                    state_reg <= ST_TRI_B;
                                end
                            end
                            REQ_EMIT: begin
                                phase_reg <= r_ph;
                                ptr_reg   <= r_ptr;
                                half_reg  <= r_half;
                                state_reg <= (r_ph == PH_DONE) ? ST_EM_NONE : ST_EM_FETCH;
                            end
                            REQ_CLEAR: begin
                                fc_reg    <= '0;
                                ovf_reg   <= 1'b0;
                                phase_reg <= PH_FACES;
                                ptr_reg   <= '0;
                                half_reg  <= 1'b0;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_TRI_B: begin
                    va_reg    <= vrd_reg;
                    state_reg <= ST_TRI_C;
                end
                ST_TRI_C: begin
                    vb_reg    <= vrd_reg;
                    state_reg <= ST_TRI_F;
                end
                ST_TRI_F: begin
                    state_reg <= ST_TRI_WAIT;
                end
                ST_TRI_WAIT: begin
                    if (f_valid) begin
                        if (!f_lit) begin
                            state_reg <= ST_IDLE;
                        end else if (fc_reg == FC_W'(MAX_FACES)) begin
                            ovf_reg   <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else begin
                            fc_reg    <= fc_reg + FC_W'(1);
                            state_reg <= ST_EDGE0;
                        end
                    end
                end
                ST_EDGE0: state_reg <= ST_EDGE1;
                ST_EDGE1: state_reg <= ST_EDGE2;
                ST_EDGE2: state_reg <= ST_IDLE;
                ST_EM_FETCH: begin
                    // Pick the three corners and their w for this triangle.
                    unique case (phase_reg)
                        PH_FACES: begin
                            vi_reg[0] <= frd_reg.a;
                            vi_reg[1] <= frd_reg.b;
                            vi_reg[2] <= frd_reg.c;
                            vw_reg    <= 3'b000;
                            ptr_reg   <= ptr_reg + PTR_W'(1);
                        end
                        PH_BACK: begin
                            vi_reg[0] <= frd_reg.c;
                            vi_reg[1] <= frd_reg.b;
                            vi_reg[2] <= frd_reg.a;
                            vw_reg    <= 3'b111;
                            ptr_reg   <= ptr_reg + PTR_W'(1);
                        end
                        default: begin
                            if (!half_reg) begin
                                vi_reg[0] <= erd_data.a;
                                vi_reg[1] <= erd_data.a;
                                vi_reg[2] <= erd_data.b;
                                vw_reg    <= 3'b010;
                                half_reg  <= 1'b1;
                            end else begin
                                vi_reg[0] <= erd_data.b;
                                vi_reg[1] <= erd_data.a;
                                vi_reg[2] <= erd_data.b;
                                vw_reg    <= 3'b110;
                                half_reg  <= 1'b0;
                                ptr_reg   <= ptr_reg + PTR_W'(1);
                            end
                        end
                    endcase
                    k_reg     <= '0;
                    state_reg <= ST_EM_RD;
                end
                ST_EM_RD: begin
                    state_reg <= ST_EM_OUT;
                end
                ST_EM_OUT: begin
                    if (out_free) begin
                        m_pos_reg   <= vrd_reg;
                        m_w_reg     <= vw_reg[k_reg];
                        m_last_reg  <= (k_reg == 2'd2);
                        m_none_reg  <= 1'b0;
                        m_ovf_reg   <= ovf_reg;
                        if (k_reg == 2'd2) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= ST_EM_RD;
                        end
                    end
                end
                ST_EM_NONE: begin
                    if (out_free) begin
                        m_pos_reg   <= '0;
                        m_w_reg     <= 1'b0;
                        m_last_reg  <= 1'b0;
                        m_none_reg  <= 1'b1;
                        m_ovf_reg   <= ovf_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_pos_x            = m_pos_reg.x;
    assign m_pos_y            = m_pos_reg.y;
    assign m_pos_z            = m_pos_reg.z;
    assign m_pos_w            = m_w_reg;
    assign m_last_of_triangle = m_last_reg;
    assign m_nothing_left     = m_none_reg;
    assign m_overflow         = m_ovf_reg;

    `SVSB_ASSERT_IMP(a_face_bound, aclk, aresetn, 1'b1, fc_reg <= FC_W'(MAX_FACES))
    `SVSB_ASSERT_IMP(a_none_clean, aclk, aresetn, m_valid_reg && m_none_reg,
                     !m_last_reg && !m_w_reg)

endmodule

`default_nettype wire
